// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the date-time validator checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define DTSV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtsv assertion failed");

// next-cycle implication, disabled during reset
`define DTSV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtsv assertion failed");

`endif

// File: design/dtsv_pkg.sv
// ----------------------------------------------------------------------------
// dtsv_pkg
// types, constants and helpers shared by the date-time string validator
// ----------------------------------------------------------------------------
package dtsv_pkg;

    localparam int YEAR_W  = 14;
    localparam int FIELD_W = 7;
    localparam int POS_W   = 5;
    localparam int CHAR_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int MDAY_W  = 5;

    // character codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;

    // string positions
    localparam logic [POS_W-1:0] POS_DASH_A  = 5'd4;
    localparam logic [POS_W-1:0] POS_DASH_B  = 5'd7;
    localparam logic [POS_W-1:0] POS_SPACE   = 5'd10;
    localparam logic [POS_W-1:0] POS_COLON_A = 5'd13;
    localparam logic [POS_W-1:0] POS_COLON_B = 5'd16;
    localparam logic [POS_W-1:0] POS_YEAR_HI = 5'd1;
    localparam logic [POS_W-1:0] POS_YEAR_LO = 5'd3;
    localparam logic [POS_W-1:0] POS_MONTH   = 5'd6;
    localparam logic [POS_W-1:0] POS_DAY     = 5'd9;
    localparam logic [POS_W-1:0] POS_HOUR    = 5'd12;
    localparam logic [POS_W-1:0] POS_MINUTE  = 5'd15;
    localparam logic [POS_W-1:0] POS_LAST    = 5'd18;
    localparam logic [POS_W-1:0] STR_LEN     = 5'd19;
    localparam logic [POS_W-1:0] POS_MAX     = 5'd31;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_YEAR_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_YEAR_MAX = 2'd1;

    localparam logic [YEAR_W-1:0] YEAR_MIN_RST = 14'd1900;
    localparam logic [YEAR_W-1:0] YEAR_MAX_RST = 14'd2100;

    // range limits
    localparam logic [FIELD_W-1:0] MONTH_FIRST = 7'd1;
    localparam logic [FIELD_W-1:0] MONTH_LAST  = 7'd12;
    localparam logic [FIELD_W-1:0] DAY_FIRST   = 7'd1;
    localparam logic [FIELD_W-1:0] HOUR_MAX    = 7'd23;
    localparam logic [FIELD_W-1:0] MINSEC_MAX  = 7'd59;

    localparam logic [FIELD_W-1:0] MONTH_FEB = 7'd2;
    localparam logic [FIELD_W-1:0] MONTH_APR = 7'd4;
    localparam logic [FIELD_W-1:0] MONTH_JUN = 7'd6;
    localparam logic [FIELD_W-1:0] MONTH_SEP = 7'd9;
    localparam logic [FIELD_W-1:0] MONTH_NOV = 7'd11;

    localparam logic [MDAY_W-1:0] DAYS_31   = 5'd31;
    localparam logic [MDAY_W-1:0] DAYS_30   = 5'd30;
    localparam logic [MDAY_W-1:0] DAYS_LEAP = 5'd29;
    localparam logic [MDAY_W-1:0] DAYS_FEB  = 5'd28;

    typedef struct packed {
        logic               fmt_ok;
        logic               leap;
        logic [YEAR_W-1:0]  year;
        logic [FIELD_W-1:0] month;
        logic [FIELD_W-1:0] day;
        logic [FIELD_W-1:0] hour;
        logic [FIELD_W-1:0] minute;
        logic [FIELD_W-1:0] second;
    } dtsv_fields_t;

    function automatic logic [MDAY_W-1:0] month_days(input logic [FIELD_W-1:0] m,
                                                     input logic leap);
        logic [MDAY_W-1:0] n;
        case (m)
            MONTH_FEB: n = leap ? DAYS_LEAP : DAYS_FEB;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: n = DAYS_30;
            default: n = DAYS_31;
        endcase
        return n;
    endfunction

endpackage

// File: design/datetime_string_validator.sv
// ----------------------------------------------------------------------------
// datetime_string_validator
// Checks a YYYY-MM-DD HH:MM:SS string fed one byte per cycle, when in_stall
// is low, and flags the final byte with last. Bytes are taken back to back
// with no gaps between strings. Each byte marked last yields one result
// word, via the capture register (the decoded fields) and then the output
// register (year-window, calendar and time range compares). A stalled output
// backs up through this two-word pipeline before input stall rises. The user
// must write year_min and year_max through the cfg port (index 0 and 1)
// only with no string in flight (not enforced here); cfg_ready is always high.
// ----------------------------------------------------------------------------
module datetime_string_validator
    import dtsv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [YEAR_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [CHAR_W-1:0]    ch,
    input  logic                 last,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 valid_res,
    output logic [YEAR_W-1:0]    year,
    output logic [FIELD_W-1:0]   month,
    output logic [FIELD_W-1:0]   day,
    output logic [FIELD_W-1:0]   hour,
    output logic [FIELD_W-1:0]   minute,
    output logic [FIELD_W-1:0]   second
);

    logic [YEAR_W-1:0]  year_min_reg;
    logic [YEAR_W-1:0]  year_max_reg;
    logic               in_fire;
    dtsv_fields_t       parsed;
    logic               cap_valid_reg, cap_valid_next;
    dtsv_fields_t       cap_reg;
    logic               out_valid_reg, out_valid_next;
    logic               out_load;
    logic               ok;
    logic               res_ok_reg;
    logic [YEAR_W-1:0]  res_year_reg;
    logic [FIELD_W-1:0] res_month_reg;
    logic [FIELD_W-1:0] res_day_reg;
    logic [FIELD_W-1:0] res_hour_reg;
    logic [FIELD_W-1:0] res_minute_reg;
    logic [FIELD_W-1:0] res_second_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_min_reg <= YEAR_MIN_RST;
            year_max_reg <= YEAR_MAX_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_YEAR_MIN)
                year_min_reg <= cfg_data;
            else if (cfg_index == CFG_YEAR_MAX)
                year_max_reg <= cfg_data;
        end
    end

    // handshake
    assign out_load = !out_valid_reg || !out_stall;
    assign in_stall = cap_valid_reg && !out_load;
    assign in_fire  = in_valid && !in_stall;

    dtsv_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (in_fire),
        .ch     (ch),
        .last   (last),
        .fields (parsed)
    );

    always_comb
    begin
        if (in_fire && last)
            cap_valid_next = 1'b1;
        else if (out_load)
            cap_valid_next = 1'b0;
        else
            cap_valid_next = cap_valid_reg;
        out_valid_next = out_load ? cap_valid_reg : out_valid_reg;
    end

    // range checks on the captured word
    always_comb
    begin
        ok = cap_reg.fmt_ok
            && (cap_reg.year >= year_min_reg) && (cap_reg.year <= year_max_reg)
            && (cap_reg.month >= MONTH_FIRST) && (cap_reg.month <= MONTH_LAST)
            && (cap_reg.day >= DAY_FIRST)
            && (cap_reg.day <= {2'd0, month_days(cap_reg.month, cap_reg.leap)})
            && (cap_reg.hour <= HOUR_MAX)
            && (cap_reg.minute <= MINSEC_MAX)
            && (cap_reg.second <= MINSEC_MAX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_valid_reg <= cap_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && last)
            cap_reg <= parsed;
        if (out_load && cap_valid_reg)
        begin
            res_ok_reg     <= ok;
            res_year_reg   <= cap_reg.year;
            res_month_reg  <= cap_reg.month;
            res_day_reg    <= cap_reg.day;
            res_hour_reg   <= cap_reg.hour;
            res_minute_reg <= cap_reg.minute;
            res_second_reg <= cap_reg.second;
        end
    end

    assign out_valid = out_valid_reg;
    assign valid_res = res_ok_reg;
    assign year      = res_year_reg;
    assign month     = res_month_reg;
    assign day       = res_day_reg;
    assign hour      = res_hour_reg;
    assign minute    = res_minute_reg;
    assign second    = res_second_reg;

endmodule

// File: design/dtsv_parse.sv
// ----------------------------------------------------------------------------
// dtsv_parse
// per-character format check and decimal field accumulation
// ----------------------------------------------------------------------------
module dtsv_parse
    import dtsv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [CHAR_W-1:0] ch,
    input  logic              last,
    output dtsv_fields_t      fields
);

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               err_reg, err_next;
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [FIELD_W-1:0] yhi_reg, yhi_next;
    logic [FIELD_W-1:0] ylo_reg, ylo_next;
    logic [FIELD_W-1:0] month_reg, month_next;
    logic [FIELD_W-1:0] day_reg, day_next;
    logic [FIELD_W-1:0] hour_reg, hour_next;
    logic [FIELD_W-1:0] minute_reg, minute_next;
    logic [FIELD_W-1:0] second_reg, second_next;
    logic               digit;
    logic [FIELD_W-1:0] d7;
    logic [YEAR_W-1:0]  d14;
    logic               fmt_ok;
    logic               leap;

    always_comb
    begin
        digit       = (ch >= CH_ZERO) && (ch <= CH_NINE);
        d7          = {3'd0, ch[3:0]};
        d14         = {10'd0, ch[3:0]};
        err_next    = err_reg;
        year_next   = year_reg;
        yhi_next    = yhi_reg;
        ylo_next    = ylo_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        if (pos_reg >= STR_LEN)
        begin
            err_next = 1'b1;
        end
        else
        begin
            case (pos_reg)
                POS_DASH_A, POS_DASH_B:
                begin
                    if (ch != CH_DASH)
                        err_next = 1'b1;
                end
                POS_SPACE:
                begin
                    if (ch != CH_SPACE)
                        err_next = 1'b1;
                end
                POS_COLON_A, POS_COLON_B:
                begin
                    if (ch != CH_COLON)
                        err_next = 1'b1;
                end
                default:
                begin
                    if (!digit)
                        err_next = 1'b1;
                    else if (pos_reg <= POS_YEAR_LO)
                    begin
                        year_next = (year_reg << 3) + (year_reg << 1) + d14;
                        if (pos_reg <= POS_YEAR_HI)
                            yhi_next = (yhi_reg << 3) + (yhi_reg << 1) + d7;
                        else
                            ylo_next = (ylo_reg << 3) + (ylo_reg << 1) + d7;
                    end
                    else if (pos_reg <= POS_MONTH)
                        month_next = (month_reg << 3) + (month_reg << 1) + d7;
                    else if (pos_reg <= POS_DAY)
                        day_next = (day_reg << 3) + (day_reg << 1) + d7;
                    else if (pos_reg <= POS_HOUR)
                        hour_next = (hour_reg << 3) + (hour_reg << 1) + d7;
                    else if (pos_reg <= POS_MINUTE)
                        minute_next = (minute_reg << 3) + (minute_reg << 1) + d7;
                    else
                        second_next = (second_reg << 3) + (second_reg << 1) + d7;
                end
            endcase
        end
        pos_next = (pos_reg < POS_MAX) ? pos_reg + 5'd1 : pos_reg;
        fmt_ok   = !err_next && (pos_reg == POS_LAST);
        // two low digits zero: century year, leap only on the upper pair
        leap     = (ylo_next == '0) ? (yhi_next[1:0] == 2'd0) : (ylo_next[1:0] == 2'd0);

        fields.fmt_ok = fmt_ok;
        fields.leap   = fmt_ok & leap;
        fields.year   = fmt_ok ? year_next   : '0;
        fields.month  = fmt_ok ? month_next  : '0;
        fields.day    = fmt_ok ? day_next    : '0;
        fields.hour   = fmt_ok ? hour_next   : '0;
        fields.minute = fmt_ok ? minute_next : '0;
        fields.second = fmt_ok ? second_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            err_reg    <= 1'b0;
            year_reg   <= '0;
            yhi_reg    <= '0;
            ylo_reg    <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                pos_reg    <= '0;
                err_reg    <= 1'b0;
                year_reg   <= '0;
                yhi_reg    <= '0;
                ylo_reg    <= '0;
                month_reg  <= '0;
                day_reg    <= '0;
                hour_reg   <= '0;
                minute_reg <= '0;
                second_reg <= '0;
            end
            else
            begin
                pos_reg    <= pos_next;
                err_reg    <= err_next;
                year_reg   <= year_next;
                yhi_reg    <= yhi_next;
                ylo_reg    <= ylo_next;
                month_reg  <= month_next;
                day_reg    <= day_next;
                hour_reg   <= hour_next;
                minute_reg <= minute_next;
                second_reg <= second_next;
            end
        end
    end

endmodule

// File: design/dtsv_checker.sv
// ----------------------------------------------------------------------------
// dtsv_checker
// port-level checks on the input and result channels, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dtsv_checker
    import dtsv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [CHAR_W-1:0]    ch,
    input  logic                 last,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 valid_res,
    input  logic [YEAR_W-1:0]    year,
    input  logic [FIELD_W-1:0]   month,
    input  logic [FIELD_W-1:0]   day,
    input  logic [FIELD_W-1:0]   hour,
    input  logic [FIELD_W-1:0]   minute,
    input  logic [FIELD_W-1:0]   second
);

    // stalled input word holds
    `DTSV_ASSERT_NXT(a_in_hold, clk, rst_n, in_valid && in_stall,
        in_valid && $stable(ch) && $stable(last))

    // stalled result word holds
    `DTSV_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(valid_res) && $stable(year) && $stable(month)
        && $stable(day) && $stable(hour) && $stable(minute) && $stable(second))

    // a valid date has a real month and day
    `DTSV_ASSERT_IMP(a_valid_date, clk, rst_n, out_valid && valid_res,
        month >= MONTH_FIRST && month <= MONTH_LAST && day >= DAY_FIRST && day <= 7'd31)

    // a valid time of day
    `DTSV_ASSERT_IMP(a_valid_time, clk, rst_n, out_valid && valid_res,
        hour <= HOUR_MAX && minute <= MINSEC_MAX && second <= MINSEC_MAX)

    // february never past the leap day, and short months never reach 31
    `DTSV_ASSERT_IMP(a_valid_mdays, clk, rst_n, out_valid && valid_res,
        (month != MONTH_FEB || day <= 7'd29)
        && (day != 7'd31 || (month != MONTH_APR && month != MONTH_JUN
        && month != MONTH_SEP && month != MONTH_NOV)))

endmodule

bind datetime_string_validator dtsv_checker u_dtsv_checker (.*);
